// File: hdl/pfla_pkg.sv
`default_nettype none

package pfla_pkg;

    // Geometry
    localparam int PAGE_NUM_BITS_DEF = 16;
    localparam int PAGE_SHIFT        = 12;
    localparam int ADDR_W            = 32;
    localparam int COUNT_W           = 17;
    localparam int CLAIM_CNT_W       = ADDR_W - PAGE_SHIFT;
    localparam int KIB_W             = 19;
    localparam int KIB_SHIFT         = 10;
    localparam int CMD_W             = 2;
    localparam int STATUS_W          = 2;
    localparam int CFG_IDX_W         = 1;
    localparam int UPC_W             = 5;

    // Register reset values
    localparam logic [ADDR_W-1:0] PROTECTED_LIMIT_RST = 32'h0044_FFFF;
    localparam logic [KIB_W-1:0]  MEMORY_KIB_RST      = 19'd262144;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_KIB      = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // Microcode step addresses
    localparam logic [UPC_W-1:0] UA_IDLE       = 5'd0;
    localparam logic [UPC_W-1:0] UA_DISPATCH   = 5'd4;  // + 4 * command
    localparam logic [UPC_W-1:0] UA_FREE       = 5'd4;
    localparam logic [UPC_W-1:0] UA_ALLOC      = 5'd8;
    localparam logic [UPC_W-1:0] UA_POP_RD     = 5'd9;
    localparam logic [UPC_W-1:0] UA_POP_WB     = 5'd10;
    localparam logic [UPC_W-1:0] UA_EMPTY      = 5'd11;
    localparam logic [UPC_W-1:0] UA_CLAIM      = 5'd12;
    localparam logic [UPC_W-1:0] UA_CLAIM_STEP = 5'd13;
    localparam logic [UPC_W-1:0] UA_CLAIM_END  = 5'd14;
    localparam logic [UPC_W-1:0] UA_NOP        = 5'd16;
    localparam logic [UPC_W-1:0] UA_DONE       = 5'd20;

    typedef enum logic [2:0] {
        JC_NEXT,          // step + 1
        JC_ALWAYS,        // target
        JC_DISPATCH,      // on accept: target + 4 * command, else hold
        JC_IF_EMPTY,      // list empty: target, else step + 1
        JC_IF_CLAIM_ZERO, // no pages left: target, else step + 1
        JC_IF_CLAIM_MORE, // more pages after this one: target, else step + 1
        JC_IF_OUT_FREE    // output slot free: target, else hold
    } jump_cond_t;

    typedef struct packed {
        logic in_ready;   // open the request channel
        logic load;       // capture request fields on accept
        logic push;       // push the candidate page
        logic range_chk;  // qualify push with the claim window
        logic adv;        // step the claim walker
        logic pop_rd;     // read head link, report head page
        logic head_ld;    // head <- link read data
        logic set_empty;  // report empty list
        logic out_load;   // move result to output register
    } ucode_ctl_t;

    typedef struct packed {
        ucode_ctl_t          ctl;
        jump_cond_t          jc;
        logic [UPC_W-1:0]    target;
    } ucode_word_t;

    typedef struct packed {
        logic empty;
        logic claim_zero;
        logic claim_more;
        logic out_free;
    } dp_status_t;

    function automatic ucode_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_word_t w;
        w = '0;
        unique case (addr)
            UA_IDLE:
            begin
                w.ctl.in_ready = 1'b1;
                w.ctl.load     = 1'b1;
                w.jc           = JC_DISPATCH;
                w.target       = UA_DISPATCH;
            end
            UA_FREE:
            begin
                w.ctl.push = 1'b1;
                w.jc       = JC_ALWAYS;
                w.target   = UA_DONE;
            end
            UA_ALLOC:
            begin
                w.jc     = JC_IF_EMPTY;
                w.target = UA_EMPTY;
            end
            UA_POP_RD:
            begin
                w.ctl.pop_rd = 1'b1;
                w.jc         = JC_NEXT;
            end
            UA_POP_WB:
            begin
                w.ctl.head_ld = 1'b1;
                w.jc          = JC_ALWAYS;
                w.target      = UA_DONE;
            end
            UA_EMPTY:
            begin
                w.ctl.set_empty = 1'b1;
                w.jc            = JC_ALWAYS;
                w.target        = UA_DONE;
            end
            UA_CLAIM:
            begin
                w.jc     = JC_IF_CLAIM_ZERO;
                w.target = UA_DONE;
            end
            UA_CLAIM_STEP:
            begin
                w.ctl.push      = 1'b1;
                w.ctl.range_chk = 1'b1;
                w.ctl.adv       = 1'b1;
                w.jc            = JC_IF_CLAIM_MORE;
                w.target        = UA_CLAIM_STEP;
            end
            UA_CLAIM_END, UA_NOP:
            begin
                w.jc     = JC_ALWAYS;
                w.target = UA_DONE;
            end
            UA_DONE:
            begin
                w.ctl.out_load = 1'b1;
                w.jc           = JC_IF_OUT_FREE;
                w.target       = UA_IDLE;
            end
            default:
            begin
                w.jc     = JC_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pfla_useq.sv
`default_nettype none

module pfla_useq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [pfla_pkg::CMD_W-1:0]   cmd,
    input  wire pfla_pkg::dp_status_t         dp_status,
    output pfla_pkg::ucode_ctl_t              ctl
);

    logic [pfla_pkg::UPC_W-1:0] upc_reg;
    logic [pfla_pkg::UPC_W-1:0] upc_next;
    logic [pfla_pkg::UPC_W-1:0] upc_inc;
    logic [pfla_pkg::UPC_W-1:0] dispatch_addr;
    pfla_pkg::ucode_word_t      word;

    assign word          = pfla_pkg::ucode_rom(upc_reg);
    assign ctl           = word.ctl;
    assign upc_inc       = upc_reg + 1'b1;
    // command selects one of four 4-step slots
    assign dispatch_addr = word.target + {{(pfla_pkg::UPC_W-pfla_pkg::CMD_W-2){1'b0}}, cmd, 2'b00};

    always_comb
    begin
        unique case (word.jc)
            pfla_pkg::JC_NEXT:          upc_next = upc_inc;
            pfla_pkg::JC_ALWAYS:        upc_next = word.target;
            pfla_pkg::JC_DISPATCH:      upc_next = accept ? dispatch_addr : upc_reg;
            pfla_pkg::JC_IF_EMPTY:      upc_next = dp_status.empty ? word.target : upc_inc;
            pfla_pkg::JC_IF_CLAIM_ZERO: upc_next = dp_status.claim_zero ? word.target : upc_inc;
            pfla_pkg::JC_IF_CLAIM_MORE: upc_next = dp_status.claim_more ? word.target : upc_inc;
            pfla_pkg::JC_IF_OUT_FREE:   upc_next = dp_status.out_free ? word.target : upc_reg;
            default:                    upc_next = pfla_pkg::UA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pfla_pkg::UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pfla_datapath.sv
`default_nettype none

module pfla_datapath #(
    parameter int PAGE_NUM_BITS = pfla_pkg::PAGE_NUM_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pfla_pkg::ucode_ctl_t              ctl,
    input  wire logic                              accept,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       page_addr,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       claim_bytes,
    input  wire logic                              cfg_we,
    input  wire logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       cfg_data,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [pfla_pkg::ADDR_W-1:0]            alloc_addr,
    output logic [pfla_pkg::STATUS_W-1:0]          status,
    output logic [pfla_pkg::COUNT_W-1:0]           pages_added,
    output logic [pfla_pkg::COUNT_W-1:0]           free_count,
    output pfla_pkg::dp_status_t                   dp_status
);

    localparam int ADDR_W  = pfla_pkg::ADDR_W;
    localparam int COUNT_W = pfla_pkg::COUNT_W;
    localparam int DEPTH   = 1 << PAGE_NUM_BITS;
    localparam int TOP_SH  = pfla_pkg::PAGE_SHIFT + PAGE_NUM_BITS;
    // count and pages_added stop at the table size or the field maximum
    localparam logic [COUNT_W-1:0] SAT_MAX =
        (PAGE_NUM_BITS >= COUNT_W) ? {COUNT_W{1'b1}} : COUNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << pfla_pkg::PAGE_SHIFT;

    logic [PAGE_NUM_BITS-1:0] link_mem [DEPTH];
    logic [PAGE_NUM_BITS-1:0] link_rdata_reg;

    logic [ADDR_W-1:0]               limit_reg;
    logic [pfla_pkg::KIB_W-1:0]      mem_kib_reg;
    logic [PAGE_NUM_BITS-1:0]        head_reg;
    logic [PAGE_NUM_BITS-1:0]        head_next;
    logic [COUNT_W-1:0]              count_reg;
    logic [COUNT_W-1:0]              count_next;

    logic [ADDR_W-1:0]                  cur_addr_reg;
    logic [pfla_pkg::CLAIM_CNT_W-1:0]   remain_reg;

    logic [ADDR_W-1:0]             res_addr_reg;
    logic [pfla_pkg::STATUS_W-1:0] res_status_reg;
    logic [COUNT_W-1:0]            res_added_reg;

    logic                          out_valid_reg;
    logic [ADDR_W-1:0]             out_addr_reg;
    logic [pfla_pkg::STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]            out_added_reg;
    logic [COUNT_W-1:0]            out_count_reg;

    logic [pfla_pkg::KIB_W+pfla_pkg::KIB_SHIFT-1:0] mem_top;
    logic                     in_window;
    logic                     cand_fits;
    logic                     push_try;
    logic                     push_do;
    logic                     push_bad;
    logic [PAGE_NUM_BITS-1:0] cand_page;
    logic                     out_free;
    logic                     out_fire;

    assign mem_top   = {mem_kib_reg, {pfla_pkg::KIB_SHIFT{1'b0}}};
    assign in_window = (cur_addr_reg > limit_reg) && (cur_addr_reg < ADDR_W'(mem_top))
                       && (cur_addr_reg != '0);
    assign cand_fits = (cur_addr_reg >> TOP_SH) == '0;
    assign cand_page = cur_addr_reg[pfla_pkg::PAGE_SHIFT +: PAGE_NUM_BITS];
    assign push_try  = ctl.push && (!ctl.range_chk || in_window);
    assign push_do   = push_try && cand_fits;
    assign push_bad  = push_try && !cand_fits;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_fire  = ctl.out_load && out_free;

    assign dp_status.empty      = (count_reg == '0);
    assign dp_status.claim_zero = (remain_reg == '0);
    assign dp_status.claim_more = (remain_reg != pfla_pkg::CLAIM_CNT_W'(1));
    assign dp_status.out_free   = out_free;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (push_do)
        begin
            head_next = cand_page;
            if (count_reg < SAT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (ctl.pop_rd)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (ctl.head_ld)
        begin
            head_next = link_rdata_reg;
        end
    end

    // link table: one write and one read port
    always_ff @(posedge clk)
    begin
        if (push_do)
        begin
            link_mem[cand_page] <= head_reg;
        end
        if (ctl.pop_rd)
        begin
            link_rdata_reg <= link_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= pfla_pkg::PROTECTED_LIMIT_RST;
            mem_kib_reg   <= pfla_pkg::MEMORY_KIB_RST;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pfla_pkg::CFG_PROTECTED_LIMIT: limit_reg   <= cfg_data;
                    pfla_pkg::CFG_MEMORY_KIB:      mem_kib_reg <= cfg_data[pfla_pkg::KIB_W-1:0];
                    default:                       limit_reg   <= limit_reg;
                endcase
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, walker and working result
    always_ff @(posedge clk)
    begin
        if (ctl.load && accept)
        begin
            cur_addr_reg   <= {page_addr[ADDR_W-1:pfla_pkg::PAGE_SHIFT],
                               {pfla_pkg::PAGE_SHIFT{1'b0}}};
            remain_reg     <= claim_bytes[ADDR_W-1:pfla_pkg::PAGE_SHIFT];
            res_addr_reg   <= '0;
            res_status_reg <= pfla_pkg::STATUS_OK;
            res_added_reg  <= '0;
        end
        else
        begin
            if (ctl.adv)
            begin
                cur_addr_reg <= cur_addr_reg + PAGE_BYTES;
                remain_reg   <= remain_reg - 1'b1;
            end
            if (push_do && (res_added_reg < SAT_MAX))
            begin
                res_added_reg <= res_added_reg + 1'b1;
            end
            if (push_bad)
            begin
                res_status_reg <= pfla_pkg::STATUS_RANGE;
            end
            else if (ctl.set_empty)
            begin
                res_status_reg <= pfla_pkg::STATUS_EMPTY;
            end
            if (ctl.pop_rd)
            begin
                res_addr_reg <= ADDR_W'(head_reg) << pfla_pkg::PAGE_SHIFT;
            end
        end
        if (out_fire)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_added_reg  <= res_added_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign alloc_addr  = out_addr_reg;
    assign status      = out_status_reg;
    assign pages_added = out_added_reg;
    assign free_count  = out_count_reg;

endmodule

`default_nettype wire

// File: hdl/page_free_list_allocator_top.sv
// LIFO free page list: free / alloc / claim over a next-link table of 2^PAGE_NUM_BITS pages.
// Each command runs its control ROM steps, then the done step loads the result for out_valid:
// free pushes a page; alloc checks for an empty list, reads the head link, reloads the head;
// claim walks one page per cycle for N = claim_bytes/4096 pages; an unused command does nothing.
// One request in flight; the next request can be accepted in the cycle after the result loads.
// Reset (rst_n, async, active low): empty list, head 0, registers to defaults; no link clear.
`default_nettype none

module page_free_list_allocator_top #(
    parameter int PAGE_NUM_BITS = pfla_pkg::PAGE_NUM_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [pfla_pkg::CMD_W-1:0]        command,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       page_addr,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       claim_bytes,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [pfla_pkg::ADDR_W-1:0]            alloc_addr,
    output logic [pfla_pkg::STATUS_W-1:0]          status,
    output logic [pfla_pkg::COUNT_W-1:0]           pages_added,
    output logic [pfla_pkg::COUNT_W-1:0]           free_count,
    // register write port
    input  wire logic                              cfg_we,
    input  wire logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       cfg_data
);

    pfla_pkg::ucode_ctl_t ctl;
    pfla_pkg::dp_status_t dp_status;
    logic                 accept;

    // in_ready comes straight from the idle control word, never from in_valid
    assign in_ready = ctl.in_ready;
    assign accept   = in_valid && ctl.in_ready;

    // Sequencer: step counter + control ROM. Idle step dispatches on command
    // into 4-step slots; claim loops on its step while pages remain.
    pfla_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (command),
        .dp_status (dp_status),
        .ctl       (ctl)
    );

    // Datapath: head/count, link table, claim walker, working and output result.
    pfla_datapath #(
        .PAGE_NUM_BITS (PAGE_NUM_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .accept      (accept),
        .page_addr   (page_addr),
        .claim_bytes (claim_bytes),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .alloc_addr  (alloc_addr),
        .status      (status),
        .pages_added (pages_added),
        .free_count  (free_count),
        .dp_status   (dp_status)
    );

endmodule

`default_nettype wire

// File: hdl/pfla_checker.sv
`default_nettype none

module pfla_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       alloc_addr,
    input  wire logic [pfla_pkg::STATUS_W-1:0]     status,
    input  wire logic [pfla_pkg::COUNT_W-1:0]      pages_added,
    input  wire logic [pfla_pkg::COUNT_W-1:0]      free_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alloc_addr) && $stable(free_count))
        else $error("result changed while stalled");

    // empty alloc reports nothing and an empty list
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pfla_pkg::STATUS_EMPTY
        |-> alloc_addr == '0 && pages_added == '0 && free_count == '0)
        else $error("empty result inconsistent");

    // a returned page only comes from a successful alloc
    a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alloc_addr != '0 |-> status == pfla_pkg::STATUS_OK && pages_added == '0)
        else $error("alloc result inconsistent");

    // pushed pages are on the list afterwards
    a_added_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pages_added <= free_count)
        else $error("pages_added exceeds free_count");

endmodule

bind page_free_list_allocator_top pfla_checker u_pfla_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .alloc_addr  (alloc_addr),
    .status      (status),
    .pages_added (pages_added),
    .free_count  (free_count)
);

`default_nettype wire
